// File: hw/rtl/srsr_pkg.sv
// Shared types and constants for the sprite row shrink renderer.
// Holds the pixel-skip ROM, the command and result structs and the queue sizes.
// No dependencies.
package srsr_pkg;

   localparam int PALETTE_COUNT = 256;
   localparam int PAL_DEPTH     = PALETTE_COUNT * 16;
   localparam int PAL_ADDR_W    = $clog2(PAL_DEPTH);
   // palette_number is compared against the palette count at this width
   localparam int PAL_CMP_W     = 13;
   localparam logic [PAL_CMP_W-1:0] PAL_LIMIT = PAL_CMP_W'(PALETTE_COUNT);

   localparam int ROW_PIXELS = 16;
   localparam int CMD_DEPTH  = 2;
   localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);
   localparam int RSP_DEPTH  = 4;
   localparam int RSP_PTR_W  = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W  = $clog2(RSP_DEPTH + 1);

   typedef enum logic {
      OP_DRAW      = 1'b0,
      OP_PAL_WRITE = 1'b1
   } opcode_type;

   // bit p set: destination position p is kept for that shrink code
   localparam logic [15:0] KEEP_ROM [16] = '{
      16'h0100, 16'h0110, 16'h1110, 16'h1114,
      16'h5114, 16'h5154, 16'h5554, 16'h5555,
      16'h5755, 16'h575D, 16'hD75D, 16'hD7DD,
      16'hF7DD, 16'hF7DF, 16'hFFDF, 16'hFFFF
   };

   typedef struct packed {
      opcode_type                  op;
      logic [ROW_PIXELS-1:0][3:0]  pix;      // indices in destination order
      logic [ROW_PIXELS-1:0]       keep;
      logic [3:0]                  code;
      logic                        opaque;
      logic                        pal_ok;
      logic [7:0]                  pal;
      logic [3:0]                  color_index;
      logic [15:0]                 color_value;
   } cmd_type;

   typedef struct packed {
      logic [3:0]  slot_offset;
      logic [15:0] color;
      logic        write_pixel;
      logic        end_of_row;
   } rsp_type;

endpackage

// File: hw/rtl/sprite_row_shrink_render.sv
// Sprite row shrink renderer: one row of sixteen 4-bit pixels in, one result
// per kept pixel out, with palette colour lookup.
//
// Request side is a queue: an item transfers when push is high and full low.
// opcode draw renders a row; opcode palette write stores one colour entry.
// Result side is a queue: the oldest result sits on the rsp_ ports while empty
// is low and transfers when pop is high.
// A draw yields shrink_code + 1 results in compacted order, the last one
// flagged by end_of_row. A palette write yields none.
// A kept pixel is read from the palette memory into a registered read stage
// and from there pushed into the result queue; skipped positions ahead of the
// first kept one delay the first result. A draw holds the row walker while it
// visits all 16 row positions, one per cycle whether kept or skipped, pausing
// on a kept pixel while the result queue lacks room. The single-port palette
// memory serves one read or one write per cycle.
// Requests queue two deep, results four deep; when the receiver stalls the
// row walker pauses on the next kept pixel and, once both queues fill, full
// rises. Reset empties both queues; palette contents are undefined until
// written, and no clearing pass runs.
module sprite_row_shrink_render
   import srsr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_opcode,
   input  logic [31:0] req_tile_first_word,
   input  logic [31:0] req_tile_second_word,
   input  logic [3:0]  req_shrink_code,
   input  logic        req_mirror,
   input  logic        req_opaque_mode,
   input  logic [7:0]  req_palette_number,
   input  logic [3:0]  req_color_index,
   input  logic [15:0] req_color_value,
   output logic        empty,
   input  logic        pop,
   output logic [3:0]  rsp_slot_offset,
   output logic [15:0] rsp_color,
   output logic        rsp_write_pixel,
   output logic        rsp_end_of_row
);

   logic                 cmd_valid;
   cmd_type              cmd;
   logic                 cmd_pop;
   logic [RSP_CNT_W-1:0] rsp_count;
   logic                 rsp_push;
   rsp_type              rsp_item;
   rsp_type              rsp_head;

   srsr_front u_front (
      .clock                (clock),
      .reset                (reset),
      .push                 (push),
      .full                 (full),
      .req_opcode           (req_opcode),
      .req_tile_first_word  (req_tile_first_word),
      .req_tile_second_word (req_tile_second_word),
      .req_shrink_code      (req_shrink_code),
      .req_mirror           (req_mirror),
      .req_opaque_mode      (req_opaque_mode),
      .req_palette_number   (req_palette_number),
      .req_color_index      (req_color_index),
      .req_color_value      (req_color_value),
      .cmd_valid            (cmd_valid),
      .cmd                  (cmd),
      .cmd_pop              (cmd_pop)
   );

   srsr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_count (rsp_count),
      .rsp_push  (rsp_push),
      .rsp_item  (rsp_item)
   );

   srsr_rsp_queue u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .item  (rsp_item),
      .count (rsp_count),
      .pop   (pop),
      .empty (empty),
      .head  (rsp_head)
   );

   assign rsp_slot_offset = rsp_head.slot_offset;
   assign rsp_color       = rsp_head.color;
   assign rsp_write_pixel = rsp_head.write_pixel;
   assign rsp_end_of_row  = rsp_head.end_of_row;

endmodule

// File: hw/rtl/srsr_front.sv
// Front end: accepts request items, unpacks and orders the pixels, looks up the
// keep mask and holds the decoded commands in a two-entry queue.
// Depends on srsr_pkg.
module srsr_front
   import srsr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_opcode,
   input  logic [31:0] req_tile_first_word,
   input  logic [31:0] req_tile_second_word,
   input  logic [3:0]  req_shrink_code,
   input  logic        req_mirror,
   input  logic        req_opaque_mode,
   input  logic [7:0]  req_palette_number,
   input  logic [3:0]  req_color_index,
   input  logic [15:0] req_color_value,
   output logic        cmd_valid,
   output cmd_type     cmd,
   input  logic        cmd_pop
);

   cmd_type                cmd_store [CMD_DEPTH];
   cmd_type                decoded;
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0]   count_ff, count_in;
   logic                   accept;
   logic                   take;

   always_comb begin
      logic [3:0]  src;
      logic [2:0]  nib;
      logic [31:0] word;
      decoded.op          = opcode_type'(req_opcode);
      decoded.keep        = KEEP_ROM[req_shrink_code];
      decoded.code        = req_shrink_code;
      decoded.opaque      = req_opaque_mode;
      decoded.pal_ok      = {{(PAL_CMP_W-8){1'b0}}, req_palette_number} < PAL_LIMIT;
      decoded.pal         = req_palette_number;
      decoded.color_index = req_color_index;
      decoded.color_value = req_color_value;
      decoded.pix         = '0;
      for (int p = 0; p < ROW_PIXELS; p++) begin
         src  = req_mirror ? 4'(15 - p) : 4'(p);
         word = src[3] ? req_tile_second_word : req_tile_first_word;
         // pixel k sits in nibble 2k (k < 4) or 2(k-4)+1
         nib  = {src[1:0], src[2]};
         decoded.pix[p] = word[{nib, 2'b00} +: 4];
      end
   end

   assign full      = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign accept    = push && !full;
   assign cmd_valid = (count_ff != '0);
   assign take      = cmd_pop && cmd_valid;
   assign cmd       = cmd_store[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CMD_CNT_W'(accept) - CMD_CNT_W'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_store[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// File: hw/rtl/srsr_back.sv
// Back end: walks each row one position a cycle, holding at a kept pixel while
// the result queue lacks room, reads kept pixels from the palette memory and
// performs palette writes in command order. Depends on srsr_pkg.
module srsr_back
   import srsr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  cmd_type              cmd,
   output logic                 cmd_pop,
   input  logic [RSP_CNT_W-1:0] rsp_count,
   output logic                 rsp_push,
   output rsp_type              rsp_item
);

   logic [15:0]           palette_mem [PAL_DEPTH];
   logic [15:0]           rd_data_ff;
   logic                  mem_we;
   logic [PAL_ADDR_W-1:0] mem_addr;

   logic [3:0] p_ff, p_in;
   logic [3:0] slot_ff, slot_in;
   logic       kept, room, step, issue;
   logic [3:0] pix;

   logic       b_valid_ff;
   logic [3:0] b_slot_ff;
   logic       b_wr_ff;
   logic       b_live_ff;
   logic       b_eor_ff;

   // conservative credit: a result still in the read stage counts as taken
   assign room = ({1'b0, rsp_count} + {{RSP_CNT_W{1'b0}}, b_valid_ff})
                 < (RSP_CNT_W+1)'(RSP_DEPTH);
   assign kept = cmd.keep[p_ff];
   assign pix  = cmd.pix[p_ff];

   always_comb begin
      mem_we   = 1'b0;
      mem_addr = PAL_ADDR_W'({cmd.pal, pix});
      cmd_pop  = 1'b0;
      step     = 1'b0;
      issue    = 1'b0;
      p_in     = p_ff;
      slot_in  = slot_ff;
      if (cmd_valid) begin
         case (cmd.op)
            OP_PAL_WRITE: begin
               mem_we   = cmd.pal_ok;
               mem_addr = PAL_ADDR_W'({cmd.pal, cmd.color_index});
               cmd_pop  = 1'b1;
            end
            OP_DRAW: begin
               step  = !kept || room;
               issue = kept && room;
               if (issue) begin
                  slot_in = slot_ff + 4'd1;
               end
               if (step) begin
                  p_in = p_ff + 4'd1;
                  if (p_ff == 4'd15) begin
                     cmd_pop = 1'b1;
                     slot_in = '0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         palette_mem[mem_addr] <= cmd.color_value;
      end
      rd_data_ff <= palette_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff       <= '0;
         slot_ff    <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         p_ff       <= p_in;
         slot_ff    <= slot_in;
         b_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         b_slot_ff <= slot_ff;
         b_wr_ff   <= cmd.opaque || (pix != 4'd0);
         b_live_ff <= (cmd.opaque || (pix != 4'd0)) && cmd.pal_ok;
         b_eor_ff  <= (slot_ff == cmd.code);
      end
   end

   assign rsp_push             = b_valid_ff;
   assign rsp_item.slot_offset = b_slot_ff;
   assign rsp_item.color       = b_live_ff ? rd_data_ff : 16'd0;
   assign rsp_item.write_pixel = b_wr_ff;
   assign rsp_item.end_of_row  = b_eor_ff;

`ifndef NO_ASSERTIONS
   // a finished row has issued exactly shrink_code + 1 pixels
   a_row_count: assert property (@(posedge clock) disable iff (reset)
      (cmd_valid && cmd.op == OP_DRAW && cmd_pop) |->
      (({1'b0, slot_ff} + {4'b0, issue}) == ({1'b0, cmd.code} + 5'd1)))
      else $error("row ended with wrong pixel count");
   a_stage_b: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> $past(issue))
      else $error("read stage valid without issue");
`endif

endmodule

// File: hw/rtl/srsr_rsp_queue.sv
// Result queue between the palette read stage and the rsp_ ports.
// Four entries; the back end only pushes when it holds a credit.
// Depends on srsr_pkg.
module srsr_rsp_queue
   import srsr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rsp_type              item,
   output logic [RSP_CNT_W-1:0] count,
   input  logic                 pop,
   output logic                 empty,
   output rsp_type              head
);

   rsp_type              entry [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic                 take;

   assign empty = (count_ff == '0);
   assign take  = pop && !empty;
   assign count = count_ff;
   assign head  = entry[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + RSP_CNT_W'(push) - RSP_CNT_W'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry[wr_ptr_ff] <= item;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !take && count_ff == RSP_CNT_W'(RSP_DEPTH)))
      else $error("result queue overflow");
   a_push_seen: assert property (@(posedge clock) disable iff (reset)
      push |=> !empty)
      else $error("pushed result not visible");
`endif

endmodule

// File: sim/tb_sprite_row_shrink_render.sv
// Self-checking bench for sprite_row_shrink_render: palette writes and shrunk row draws.
// It predicts every result with its own palette copy and keep masks, and compares them in order.
// Depends on srsr_pkg (opcode_type) and the sprite_row_shrink_render RTL.
`timescale 1ns / 100ps

module tb_sprite_row_shrink_render;
   import srsr_pkg::*;

   typedef struct {
      opcode_type  op;
      logic [31:0] tile_lo;
      logic [31:0] tile_hi;
      logic [3:0]  code;
      logic        mirror;
      logic        opaque;
      logic [7:0]  pal;
      logic [3:0]  cidx;
      logic [15:0] cval;
   } sprite_cmd_type;

   typedef struct {
      logic [3:0]  slot;
      logic [15:0] colour;
      logic        wr;
      logic        last;
   } pixel_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        pop = 1'b0;
   logic        full, empty;
   logic        req_opcode = 1'b0;
   logic [31:0] req_tile_first_word = '0;
   logic [31:0] req_tile_second_word = '0;
   logic [3:0]  req_shrink_code = '0;
   logic        req_mirror = 1'b0;
   logic        req_opaque_mode = 1'b0;
   logic [7:0]  req_palette_number = '0;
   logic [3:0]  req_color_index = '0;
   logic [15:0] req_color_value = '0;
   logic [3:0]  rsp_slot_offset;
   logic [15:0] rsp_color;
   logic        rsp_write_pixel;
   logic        rsp_end_of_row;

   logic [15:0]      pal_colours [256][16];
   bit               pal_written [256][16];
   bit [255:0]       pal_used;
   int               used_list[$];
   pixel_result_type pending_pixels[$];
   int               err_count = 0;
   int               rsp_wait = 0;
   bit               req_no_idle = 1'b0;
   bit               rsp_no_idle = 1'b0;

   sprite_row_shrink_render dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_opcode(req_opcode), .req_tile_first_word(req_tile_first_word),
      .req_tile_second_word(req_tile_second_word), .req_shrink_code(req_shrink_code),
      .req_mirror(req_mirror), .req_opaque_mode(req_opaque_mode),
      .req_palette_number(req_palette_number), .req_color_index(req_color_index),
      .req_color_value(req_color_value), .empty(empty), .pop(pop),
      .rsp_slot_offset(rsp_slot_offset), .rsp_color(rsp_color),
      .rsp_write_pixel(rsp_write_pixel), .rsp_end_of_row(rsp_end_of_row)
   );

   always #5 clock = ~clock;

   // bit p set: destination position p survives the shrink
   function automatic logic [15:0] kept_mask(logic [3:0] code);
      case (code)
         4'd0:  return 16'h0100;
         4'd1:  return 16'h0110;
         4'd2:  return 16'h1110;
         4'd3:  return 16'h1114;
         4'd4:  return 16'h5114;
         4'd5:  return 16'h5154;
         4'd6:  return 16'h5554;
         4'd7:  return 16'h5555;
         4'd8:  return 16'h5755;
         4'd9:  return 16'h575D;
         4'd10: return 16'hD75D;
         4'd11: return 16'hD7DD;
         4'd12: return 16'hF7DD;
         4'd13: return 16'hF7DF;
         4'd14: return 16'hFFDF;
         default: return 16'hFFFF;
      endcase
   endfunction

   // pixel k of a word: nibble 2k for k < 4, else 2(k-4)+1
   function automatic int nibble_of(int src);
      int k;
      k = src % 8;
      return (k < 4) ? 2 * k : 2 * (k - 4) + 1;
   endfunction

   // updates the palette copy, or queues the pixels a draw is due to produce
   function automatic void apply_command(sprite_cmd_type c);
      int               cnt;
      int               src;
      logic [31:0]      word;
      logic [3:0]       idx;
      logic [15:0]      mask;
      pixel_result_type r;
      if (c.op == OP_PAL_WRITE) begin
         pal_colours[c.pal][c.cidx] = c.cval;
         pal_written[c.pal][c.cidx] = 1'b1;
         if (!pal_used[c.pal]) begin
            pal_used[c.pal] = 1'b1;
            used_list.push_back(int'(c.pal));
         end
         return;
      end
      cnt = 0;
      mask = kept_mask(c.code);
      for (int p = 0; p < 16; p++) begin
         if (mask[p]) begin
            src = c.mirror ? 15 - p : p;
            word = (src < 8) ? c.tile_lo : c.tile_hi;
            idx = word[4*nibble_of(src) +: 4];
            r.slot = cnt[3:0];
            r.wr = c.opaque || (idx != 4'd0);
            r.colour = r.wr ? pal_colours[c.pal][idx] : 16'h0000;
            r.last = (cnt == int'(c.code));
            pending_pixels.push_back(r);
            cnt++;
         end
      end
   endfunction

   function automatic sprite_cmd_type draw_cmd(logic [31:0] lo, logic [31:0] hi,
                                               logic [3:0] code, logic mirror,
                                               logic opaque, logic [7:0] pal);
      sprite_cmd_type c;
      c.op = OP_DRAW;
      c.tile_lo = lo;
      c.tile_hi = hi;
      c.code = code;
      c.mirror = mirror;
      c.opaque = opaque;
      c.pal = pal;
      c.cidx = 4'($urandom_range(0, 15));
      c.cval = 16'($urandom_range(0, 65535));
      return c;
   endfunction

   // tile words and draw fields are random: the block must ignore them
   function automatic sprite_cmd_type write_cmd(logic [7:0] pal, logic [3:0] cidx,
                                                logic [15:0] cval);
      sprite_cmd_type c;
      c = draw_cmd($urandom, $urandom, 4'($urandom_range(0, 15)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pal);
      c.op = OP_PAL_WRITE;
      c.cidx = cidx;
      c.cval = cval;
      return c;
   endfunction

   // kept pixels only use written entries (or index 0 when transparent); skipped ones are free
   function automatic sprite_cmd_type random_row(logic [7:0] pal, logic [3:0] code,
                                                 logic mirror, logic opaque);
      sprite_cmd_type c;
      logic [3:0]     idx;
      logic [15:0]    mask;
      int             p;
      c = draw_cmd('0, '0, code, mirror, opaque, pal);
      mask = kept_mask(code);
      for (int src = 0; src < 16; src++) begin
         p = mirror ? 15 - src : src;
         idx = 4'($urandom_range(0, 15));
         if (mask[p])
            while (!((idx == 4'd0 && !opaque) || pal_written[pal][idx]))
               idx = 4'($urandom_range(0, 15));
         if (src < 8)
            c.tile_lo[4*nibble_of(src) +: 4] = idx;
         else
            c.tile_hi[4*nibble_of(src) +: 4] = idx;
      end
      return c;
   endfunction

   task automatic send_cmd(sprite_cmd_type c);
      int gap;
      gap = req_no_idle ? 0 : $urandom_range(0, 3);
      repeat (gap) begin
         @(negedge clock);
         push <= 1'b0;
      end
      @(negedge clock);
      req_opcode <= c.op;
      req_tile_first_word <= c.tile_lo;
      req_tile_second_word <= c.tile_hi;
      req_shrink_code <= c.code;
      req_mirror <= c.mirror;
      req_opaque_mode <= c.opaque;
      req_palette_number <= c.pal;
      req_color_index <= c.cidx;
      req_color_value <= c.cval;
      push <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      apply_command(c);
   endtask

   // result side: pop held low for a random stretch after each transfer
   always @(negedge clock) begin
      if (rsp_wait > 0) begin
         pop <= 1'b0;
         rsp_wait = rsp_wait - 1;
      end else
         pop <= 1'b1;
   end

   always @(posedge clock) begin
      pixel_result_type e;
      if (!reset && pop && !empty) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t unexpected pixel: slot %0d colour %h", $time, rsp_slot_offset,
                     rsp_color);
            err_count++;
         end else begin
            e = pending_pixels.pop_front();
            if (rsp_slot_offset !== e.slot) begin
               $display("%0t slot_offset expected %0d got %0d", $time, e.slot, rsp_slot_offset);
               err_count++;
            end
            if (rsp_color !== e.colour) begin
               $display("%0t color expected %h got %h", $time, e.colour, rsp_color);
               err_count++;
            end
            if (rsp_write_pixel !== e.wr) begin
               $display("%0t write_pixel expected %b got %b", $time, e.wr, rsp_write_pixel);
               err_count++;
            end
            if (rsp_end_of_row !== e.last) begin
               $display("%0t end_of_row expected %b got %b", $time, e.last, rsp_end_of_row);
               err_count++;
            end
         end
         rsp_wait = rsp_no_idle ? 0 : $urandom_range(0, 3);
      end
   end

   // palettes 0 and 255 filled completely, extreme colours included
   task automatic test_palette_setup();
      for (int i = 0; i < 16; i++) begin
         send_cmd(write_cmd(8'h00, 4'(i),
                            (i == 0) ? 16'h0000 : 16'($urandom_range(0, 65535))));
         send_cmd(write_cmd(8'hFF, 4'(i),
                            (i == 15) ? 16'hFFFF : 16'($urandom_range(0, 65535))));
      end
   endtask

   task automatic test_row_extremes();
      send_cmd(draw_cmd(32'hFFFFFFFF, 32'hFFFFFFFF, 4'd15, 1'b0, 1'b0, 8'hFF));
      send_cmd(draw_cmd(32'hFFFFFFFF, 32'hFFFFFFFF, 4'd0, 1'b1, 1'b0, 8'hFF));
      // fully transparent row, then the same row forced opaque
      send_cmd(draw_cmd(32'h0, 32'h0, 4'd15, 1'b0, 1'b0, 8'h00));
      send_cmd(draw_cmd(32'h0, 32'h0, 4'd15, 1'b1, 1'b1, 8'hFF));
      // ramp: pixel k holds index k, exposes the interleaved nibble order
      send_cmd(draw_cmd(32'h73625140, 32'hFBEAD9C8, 4'd15, 1'b0, 1'b1, 8'h00));
      send_cmd(draw_cmd(32'h73625140, 32'hFBEAD9C8, 4'd15, 1'b1, 1'b0, 8'hFF));
      send_cmd(draw_cmd(32'h73625140, 32'hFBEAD9C8, 4'd0, 1'b0, 1'b1, 8'hFF));
   endtask

   task automatic test_every_shrink_code();
      for (int code = 0; code < 16; code++)
         send_cmd(draw_cmd(32'h73625140, 32'hFBEAD9C8, 4'(code), 1'(code % 2),
                           1'(code / 8), (code % 4 < 2) ? 8'h00 : 8'hFF));
   endtask

   // mostly draws on palettes with known entries, a steady trickle of palette writes
   task automatic test_random_traffic(int n_items);
      logic [7:0] pal;
      for (int n = 0; n < n_items; n++) begin
         if (n % 60 == 0) begin
            req_no_idle = ($urandom_range(0, 3) == 0);
            rsp_no_idle = ($urandom_range(0, 3) == 0);
         end
         if ($urandom_range(0, 3) == 0)
            send_cmd(write_cmd(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                               16'($urandom_range(0, 65535))));
         else begin
            if ($urandom_range(0, 1) == 0)
               pal = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            else
               pal = 8'(used_list[$urandom_range(0, used_list.size() - 1)]);
            send_cmd(random_row(pal, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1))));
         end
      end
   endtask

   initial begin
      pal_used = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_palette_setup();
      test_row_extremes();
      test_every_shrink_code();
      test_random_traffic(315);
      @(negedge clock);
      push <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (pending_pixels.size() == 0 && err_count == 0)
         $display("[sprite_row_shrink_render] OK");
      else
         $display("[sprite_row_shrink_render] ERROR");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[sprite_row_shrink_render] ERROR");
      $finish;
   end

endmodule
